>>> src/uart_rx_tx_ring_buffers_unit_macros.svh
// Assertion macros for the serial port ring buffer unit.
// Included by the top level; no other dependencies.
`ifndef UART_RX_TX_RING_BUFFERS_UNIT_MACROS_SVH
`define UART_RX_TX_RING_BUFFERS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define URB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urb: assertion failed");

// Next-cycle implication, disabled during reset
`define URB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urb: assertion failed");

`else

`define URB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define URB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/urb_pkg.sv
// Shared types and constants for the serial port ring buffer unit.
// No dependencies.
package urb_pkg;

  localparam int REQ_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int SIZE_W    = 7;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_RING_DEPTH = 64;
  localparam int DEF_DATA_BITS  = 8;

  // Reset value of both size registers before clamping
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_RECV  = 3'd0,
    REQ_READ  = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_TXRDY = 3'd4,
    REQ_CLEAR = 3'd5
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_DISABLED = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_SIZE  = 2'd0,
    CFG_TX_SIZE  = 2'd1,
    CFG_PORT_EN  = 2'd2
  } cfg_idx_t;

  // Configuration seen by the ring control
  typedef struct packed {
    logic [SIZE_W-1:0] rx_size;
    logic [SIZE_W-1:0] tx_size;
    logic              port_enabled;
    logic              rx_flush;
    logic              tx_flush;
  } cfg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

>>> src/urb_if.sv
// Request and result channel interfaces (valid/ready handshake).
// Depends on urb_pkg.
interface urb_in_if import urb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface urb_out_if import urb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_byte;
  logic                line_valid;
  logic [BYTE_W-1:0]   line_byte;
  logic [CNT_W-1:0]    rx_count;
  logic [CNT_W-1:0]    tx_free;
  logic                tx_irq_on;

  modport source (output valid, status, read_byte, line_valid, line_byte, rx_count,
                  tx_free, tx_irq_on, input ready);
  modport sink   (input valid, status, read_byte, line_valid, line_byte, rx_count,
                  tx_free, tx_irq_on, output ready);
endinterface

>>> src/uart_rx_tx_ring_buffers_unit.sv
// Top level: serial port receive and transmit ring buffers.
// Depends on urb_pkg, urb_if, urb_ram, urb_cfg and the assertion macro header.
//
//  channel | direction | handshake       | payload
//  in_if   | in        | valid / ready   | req_type, data_byte
//  out_if  | out       | valid / ready   | status, read_byte, line_valid, line_byte,
//          |           |                 | rx_count, tx_free, tx_irq_on
//  cfg_*   | in        | cfg_we only     | cfg_index, cfg_wdata
//
// Each request is accepted in S_IDLE, which reads the tail entry of both ring
// RAMs (registered read data); S_EXEC then updates pointers and writes back.
// The result sits in an output register; a new request is taken while it waits.
// If the output register is still full and not being taken when a request is
// done, the request holds in S_EXEC. Synchronous reset clears pointers and
// flags only; the ring stores need no clearing pass.
`include "uart_rx_tx_ring_buffers_unit_macros.svh"

module uart_rx_tx_ring_buffers_unit import urb_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int DATA_BITS  = DEF_DATA_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  urb_in_if.sink               in_if,
  urb_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CMP_W = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;

  // Pointer step with wrap at the size in use
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [SIZE_W-1:0] size);
    logic [CMP_W-1:0] inc;
    logic [PTR_W-1:0] res;
    inc = CMP_W'(p) + CMP_W'(1);
    res = PTR_W'(inc);
    if (inc == CMP_W'(size)) begin
      res = '0;
    end
    return res;
  endfunction

  // Bytes waiting in a ring
  function automatic logic [CNT_W-1:0] ring_fill(input logic [PTR_W-1:0] h,
                                                 input logic [PTR_W-1:0] t,
                                                 input logic [SIZE_W-1:0] size);
    logic [CMP_W-1:0] res;
    if (h >= t) begin
      res = CMP_W'(h) - CMP_W'(t);
    end else begin
      res = CMP_W'(size) + CMP_W'(h) - CMP_W'(t);
    end
    return res[CNT_W-1:0];
  endfunction

  // Free entries in a ring
  function automatic logic [CNT_W-1:0] ring_room(input logic [PTR_W-1:0] h,
                                                 input logic [PTR_W-1:0] t,
                                                 input logic [SIZE_W-1:0] size);
    logic [CMP_W-1:0] res;
    if (h >= t) begin
      res = CMP_W'(size) - CMP_W'(1) - CMP_W'(h) + CMP_W'(t);
    end else begin
      res = CMP_W'(t) - CMP_W'(h) - CMP_W'(1);
    end
    return res[CNT_W-1:0];
  endfunction

  cfg_t cfg;

  state_t state_r, state_nxt;

  logic [PTR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [PTR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic             tx_irq_r, tx_irq_nxt;

  logic [REQ_W-1:0]  req_r;
  logic [BYTE_W-1:0] data_r;

  logic                 rx_we, tx_we;
  logic [DATA_BITS-1:0] rx_rdata, tx_rdata, wr_data;
  logic [PTR_W-1:0]     rx_next_head, tx_next_head;

  logic                in_fire, out_load;
  status_t             status_nxt;
  logic [BYTE_W-1:0]   rbyte_nxt, lbyte_nxt;
  logic                lvalid_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [BYTE_W-1:0]   rbyte_r, lbyte_r;
  logic                lvalid_r;
  logic [CNT_W-1:0]    rx_count_r, tx_free_r;
  logic                irq_out_r;

  // Configuration registers
  urb_cfg #(.RING_DEPTH(RING_DEPTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Ring stores: read the tail on accept, write the head on completion
  assign wr_data = DATA_BITS'(data_r);

  urb_ram #(.WIDTH(DATA_BITS), .DEPTH(RING_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head_r),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (rx_tail_r),
    .rdata (rx_rdata)
  );

  urb_ram #(.WIDTH(DATA_BITS), .DEPTH(RING_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head_r),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (tx_tail_r),
    .rdata (tx_rdata)
  );

  // Handshakes
  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_load    = (state_r == S_EXEC) && (!out_valid_r || out_if.ready);

  assign rx_next_head = advance(rx_head_r, cfg.rx_size);
  assign tx_next_head = advance(tx_head_r, cfg.tx_size);

  // Request execution
  always_comb begin
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    tx_irq_nxt  = tx_irq_r;
    rx_we       = 1'b0;
    tx_we       = 1'b0;
    status_nxt  = ST_OK;
    rbyte_nxt   = '0;
    lvalid_nxt  = 1'b0;
    lbyte_nxt   = '0;
    if (out_load) begin
      case (req_r)
        REQ_RECV: begin
          if (rx_next_head == rx_tail_r) begin
            rx_tail_nxt = advance(rx_tail_r, cfg.rx_size);
            status_nxt  = ST_DROPPED;
          end
          rx_we       = 1'b1;
          rx_head_nxt = rx_next_head;
        end
        REQ_READ, REQ_PEEK: begin
          if (rx_head_r == rx_tail_r) begin
            status_nxt = ST_EMPTY;
          end else begin
            rbyte_nxt = rx_rdata[BYTE_W-1:0];
            if (req_r == REQ_READ) begin
              rx_tail_nxt = advance(rx_tail_r, cfg.rx_size);
            end
          end
        end
        REQ_WRITE: begin
          if (!cfg.port_enabled) begin
            status_nxt = ST_DISABLED;
          end else begin
            // full ring: oldest byte goes out first
            if (tx_next_head == tx_tail_r) begin
              lvalid_nxt  = 1'b1;
              lbyte_nxt   = tx_rdata[BYTE_W-1:0];
              tx_tail_nxt = advance(tx_tail_r, cfg.tx_size);
            end
            tx_we       = 1'b1;
            tx_head_nxt = tx_next_head;
            tx_irq_nxt  = 1'b1;
          end
        end
        REQ_TXRDY: begin
          if (tx_head_r == tx_tail_r) begin
            tx_irq_nxt = 1'b0;
            status_nxt = ST_EMPTY;
          end else begin
            lvalid_nxt  = 1'b1;
            lbyte_nxt   = tx_rdata[BYTE_W-1:0];
            tx_tail_nxt = advance(tx_tail_r, cfg.tx_size);
          end
        end
        REQ_CLEAR: rx_head_nxt = rx_tail_r;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_EXEC;
      S_EXEC: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Ring pointers and interrupt flag; a size write empties its ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r <= '0;
      rx_tail_r <= '0;
      tx_head_r <= '0;
      tx_tail_r <= '0;
      tx_irq_r  <= 1'b0;
    end else begin
      rx_head_r <= cfg.rx_flush ? '0 : rx_head_nxt;
      rx_tail_r <= cfg.rx_flush ? '0 : rx_tail_nxt;
      tx_head_r <= cfg.tx_flush ? '0 : tx_head_nxt;
      tx_tail_r <= cfg.tx_flush ? '0 : tx_tail_nxt;
      tx_irq_r  <= tx_irq_nxt;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= in_if.req_type;
      data_r <= in_if.data_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r   <= status_nxt;
      rbyte_r    <= rbyte_nxt;
      lvalid_r   <= lvalid_nxt;
      lbyte_r    <= lbyte_nxt;
      rx_count_r <= ring_fill(rx_head_nxt, rx_tail_nxt, cfg.rx_size);
      tx_free_r  <= ring_room(tx_head_nxt, tx_tail_nxt, cfg.tx_size);
      irq_out_r  <= tx_irq_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = status_r;
  assign out_if.read_byte  = rbyte_r;
  assign out_if.line_valid = lvalid_r;
  assign out_if.line_byte  = lbyte_r;
  assign out_if.rx_count   = rx_count_r;
  assign out_if.tx_free    = tx_free_r;
  assign out_if.tx_irq_on  = irq_out_r;

  // Checks
  `URB_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_fire, state_r == S_EXEC)
  `URB_ASSERT_NOW(a_rx_head_in_ring, clk, rst_n, 1'b1, CMP_W'(rx_head_r) < CMP_W'(cfg.rx_size))
  `URB_ASSERT_NOW(a_line_not_empty, clk, rst_n, lvalid_nxt, tx_head_r != tx_tail_r)

endmodule

>>> src/urb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/urb_cfg.sv
// Configuration registers: size clamping, port enable and ring flush pulses.
// Depends on urb_pkg.
module urb_cfg import urb_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  // Limit a size to 2 .. RING_DEPTH
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v < SIZE_W'(2)) begin
      res = SIZE_W'(2);
    end else if (32'(v) > 32'(RING_DEPTH)) begin
      res = SIZE_W'(RING_DEPTH);
    end
    return res;
  endfunction

  logic [SIZE_W-1:0] rx_size_r, rx_size_nxt;
  logic [SIZE_W-1:0] tx_size_r, tx_size_nxt;
  logic              port_en_r, port_en_nxt;
  logic              rx_flush, tx_flush;

  // Register decode
  always_comb begin
    rx_size_nxt = rx_size_r;
    tx_size_nxt = tx_size_r;
    port_en_nxt = port_en_r;
    rx_flush    = 1'b0;
    tx_flush    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RX_SIZE: begin
          rx_size_nxt = clamp_size(cfg_wdata);
          rx_flush    = 1'b1;
        end
        CFG_TX_SIZE: begin
          tx_size_nxt = clamp_size(cfg_wdata);
          tx_flush    = 1'b1;
        end
        CFG_PORT_EN: port_en_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_size_r <= clamp_size(SIZE_RESET);
      tx_size_r <= clamp_size(SIZE_RESET);
      port_en_r <= 1'b0;
    end else begin
      rx_size_r <= rx_size_nxt;
      tx_size_r <= tx_size_nxt;
      port_en_r <= port_en_nxt;
    end
  end

  assign cfg.rx_size      = rx_size_r;
  assign cfg.tx_size      = tx_size_r;
  assign cfg.port_enabled = port_en_r;
  assign cfg.rx_flush     = rx_flush;
  assign cfg.tx_flush     = tx_flush;

endmodule
